### rtl/spectral_angle_classifier_macros.svh
// Assertion macros shared by the spectral angle classifier RTL.
`ifndef SPECTRAL_ANGLE_CLASSIFIER_MACROS_SVH
`define SPECTRAL_ANGLE_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SAC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spectral angle classifier: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spectral angle classifier: next-cycle check failed");

`endif

### rtl/sac_pkg.sv
// Package with the widths, constants and shared types of the spectral angle classifier.
`default_nettype none

package sac_pkg;

   // Item field widths.
   localparam int SAMPLE_W = 16;
   localparam int COS_W    = 17;
   localparam int COS_FRAC = 16;
   localparam int CNT_W    = 32;

   // Threshold after reset: cos(0.1 rad) in Q1.16.
   localparam logic [COS_W-1:0] COS_RESET = COS_W'(65209);

   // Per-band products and per-pixel accumulators.
   localparam int PROD_W = 2 * SAMPLE_W;
   localparam int SUM_W  = 43;

   // Pixel queue between the band accumulator and the decision unit.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Digit-serial multiplier of the decision unit.
   localparam int DIGIT_W   = 8;
   localparam int MULA_W    = 2 * SUM_W;
   localparam int MULB_W    = 48;
   localparam int MUL_STEPS = MULB_W / DIGIT_W;
   localparam int STEP_W    = $clog2(MUL_STEPS);
   localparam int DPROD_W   = MULA_W + DIGIT_W;
   localparam int ACC_W     = 128;
   localparam int C2_W      = 2 * COS_W;
   localparam int LHS_W     = 2 * (SUM_W - 1);
   localparam int LHS_SHIFT = 2 * COS_FRAC;
   localparam int RHS_W     = MULA_W + C2_W;

   // Sums of one finished pixel.
   typedef struct packed {
      logic signed [SUM_W-1:0] dot;
      logic        [SUM_W-1:0] pixel_norm;
      logic        [SUM_W-1:0] ref_norm;
      logic                    invalid;
   } pixel_sums_type;

   // Write side of the pixel queue.
   typedef struct packed {
      logic           valid;
      pixel_sums_type sums;
   } fifo_push_type;

   // Fill state of the pixel queue.
   typedef struct packed {
      logic [FIFO_CNT_W-1:0] count;
      logic                  empty;
      logic                  full;
   } fifo_status_type;

endpackage

`default_nettype wire

### rtl/sac_ifs.sv
// Valid/ready channel interfaces for band items and pixel results.
`default_nettype none

interface sac_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sac_pkg::SAMPLE_W-1:0] pixel_sample;
   logic signed [sac_pkg::SAMPLE_W-1:0] ref_sample;
   logic                                sample_valid;
   logic                                last_band;

   modport source (
      output valid, pixel_sample, ref_sample, sample_valid, last_band,
      input  ready
   );
   modport sink (
      input  valid, pixel_sample, ref_sample, sample_valid, last_band,
      output ready
   );
endinterface

interface sac_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             pixel_valid;
   logic                             match;
   logic [sac_pkg::CNT_W-1:0]        matched_count;
   logic [sac_pkg::CNT_W-1:0]        total_count;

   modport source (
      output valid, pixel_valid, match, matched_count, total_count,
      input  ready
   );
   modport sink (
      input  valid, pixel_valid, match, matched_count, total_count,
      output ready
   );
endinterface

`default_nettype wire

### rtl/sac_front.sv
// Band accumulator: multiplies each band, sums dot product and norms, and queues finished pixels.
`default_nettype none

module sac_front (
   input  wire                            clock,
   input  wire                            reset,
   sac_req_if.sink                        req,
   input  wire sac_pkg::fifo_status_type  fifo_status,
   output sac_pkg::fifo_push_type         push
);

   localparam int EXT_W = sac_pkg::SUM_W + 1;
   localparam int PAD_W = EXT_W - sac_pkg::PROD_W;

   localparam logic signed [sac_pkg::SUM_W-1:0] DOT_MAX =
      {1'b0, {(sac_pkg::SUM_W-1){1'b1}}};
   localparam logic signed [sac_pkg::SUM_W-1:0] DOT_MIN =
      {1'b1, {(sac_pkg::SUM_W-1){1'b0}}};

   // Product stage.
   logic                               s1_valid_ff;
   logic                               s1_sample_ok_ff;
   logic                               s1_last_ff;
   logic signed [sac_pkg::PROD_W-1:0]  s1_dot_ff;
   logic signed [sac_pkg::PROD_W-1:0]  s1_psq_ff;
   logic signed [sac_pkg::PROD_W-1:0]  s1_rsq_ff;

   // Running sums of the current pixel.
   logic signed [sac_pkg::SUM_W-1:0]   dot_ff;
   logic        [sac_pkg::SUM_W-1:0]   pnorm_ff;
   logic        [sac_pkg::SUM_W-1:0]   rnorm_ff;
   logic                               invalid_ff;

   logic signed [sac_pkg::SUM_W-1:0]   dot_in;
   logic        [sac_pkg::SUM_W-1:0]   pnorm_in;
   logic        [sac_pkg::SUM_W-1:0]   rnorm_in;
   logic                               invalid_in;

   logic        [EXT_W-1:0]            dot_sum;
   logic        [EXT_W-1:0]            pnorm_sum;
   logic        [EXT_W-1:0]            rnorm_sum;
   logic        [sac_pkg::FIFO_CNT_W-1:0] pending;
   logic                               accept;

   // A band is taken only while the queue has room for every pixel already in flight.
   assign pending   = fifo_status.count
                    + sac_pkg::FIFO_CNT_W'(s1_valid_ff & s1_last_ff);
   assign req.ready = pending < sac_pkg::FIFO_CNT_W'(sac_pkg::FIFO_DEPTH);
   assign accept    = req.valid & req.ready;

   // Register the three products of the accepted band.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_sample_ok_ff <= req.sample_valid;
         s1_last_ff      <= req.last_band;
         s1_dot_ff       <= req.pixel_sample * req.ref_sample;
         s1_psq_ff       <= req.pixel_sample * req.pixel_sample;
         s1_rsq_ff       <= req.ref_sample * req.ref_sample;
      end
   end

   // Add the products with saturation; invalid bands only mark the pixel.
   always_comb begin
      dot_sum   = {dot_ff[sac_pkg::SUM_W-1], dot_ff}
                + {{PAD_W{s1_dot_ff[sac_pkg::PROD_W-1]}}, s1_dot_ff};
      pnorm_sum = {1'b0, pnorm_ff} + {{PAD_W{1'b0}}, s1_psq_ff};
      rnorm_sum = {1'b0, rnorm_ff} + {{PAD_W{1'b0}}, s1_rsq_ff};
      dot_in     = dot_ff;
      pnorm_in   = pnorm_ff;
      rnorm_in   = rnorm_ff;
      invalid_in = invalid_ff | ~s1_sample_ok_ff;
      if (s1_sample_ok_ff) begin
         if (dot_sum[EXT_W-1] != dot_sum[EXT_W-2]) begin
            dot_in = dot_sum[EXT_W-1] ? DOT_MIN : DOT_MAX;
         end else begin
            dot_in = dot_sum[sac_pkg::SUM_W-1:0];
         end
         pnorm_in = pnorm_sum[EXT_W-1] ? '1 : pnorm_sum[sac_pkg::SUM_W-1:0];
         rnorm_in = rnorm_sum[EXT_W-1] ? '1 : rnorm_sum[sac_pkg::SUM_W-1:0];
      end
   end

   // Keep the sums; the last band hands them to the queue and starts a new pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff     <= '0;
         pnorm_ff   <= '0;
         rnorm_ff   <= '0;
         invalid_ff <= 1'b0;
      end else if (s1_valid_ff) begin
         if (s1_last_ff) begin
            dot_ff     <= '0;
            pnorm_ff   <= '0;
            rnorm_ff   <= '0;
            invalid_ff <= 1'b0;
         end else begin
            dot_ff     <= dot_in;
            pnorm_ff   <= pnorm_in;
            rnorm_ff   <= rnorm_in;
            invalid_ff <= invalid_in;
         end
      end
   end

   assign push.valid           = s1_valid_ff & s1_last_ff;
   assign push.sums.dot        = dot_in;
   assign push.sums.pixel_norm = pnorm_in;
   assign push.sums.ref_norm   = rnorm_in;
   assign push.sums.invalid    = invalid_in;

endmodule

`default_nettype wire

### rtl/sac_fifo.sv
// Short queue of finished pixel sums between the accumulator and the decision unit.
`default_nettype none

module sac_fifo (
   input  wire                            clock,
   input  wire                            reset,
   input  wire sac_pkg::fifo_push_type    push,
   input  wire                            pop,
   output sac_pkg::fifo_status_type       status,
   output sac_pkg::pixel_sums_type        head
);

   sac_pkg::pixel_sums_type             entries_ff [sac_pkg::FIFO_DEPTH];
   logic [sac_pkg::FIFO_PTR_W-1:0]      wr_ptr_ff;
   logic [sac_pkg::FIFO_PTR_W-1:0]      rd_ptr_ff;
   logic [sac_pkg::FIFO_CNT_W-1:0]      count_ff;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push.valid, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.sums;
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == sac_pkg::FIFO_CNT_W'(sac_pkg::FIFO_DEPTH);

endmodule

`default_nettype wire

### rtl/sac_back.sv
// Decision unit: tests the angle with a digit-serial multiplier and keeps the pixel counts.
`default_nettype none

module sac_back (
   input  wire                            clock,
   input  wire                            reset,
   input  wire [sac_pkg::COS_W-1:0]       cos_threshold,
   input  wire sac_pkg::fifo_status_type  fifo_status,
   input  wire sac_pkg::pixel_sums_type   head,
   output logic                           pop,
   sac_rsp_if.source                      rsp
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOT_SQ,
      ST_NORM_PROD,
      ST_SCALE,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   localparam int DIGIT_HI = sac_pkg::MULB_W - 1;
   localparam int DIGIT_LO = sac_pkg::MULB_W - sac_pkg::DIGIT_W;
   localparam int LHS_PAD  = sac_pkg::RHS_W - sac_pkg::LHS_W - sac_pkg::LHS_SHIFT;

   state_type                          state_ff;
   sac_pkg::pixel_sums_type            sums_ff;
   logic [sac_pkg::COS_W-1:0]          cos_ff;
   logic [sac_pkg::C2_W-1:0]           cos_sq_ff;
   logic [sac_pkg::MULA_W-1:0]         mul_a_ff;
   logic [sac_pkg::MULB_W-1:0]         mul_b_ff;
   logic [sac_pkg::ACC_W-1:0]          mul_acc_ff;
   logic [sac_pkg::STEP_W-1:0]         step_ff;
   logic [sac_pkg::LHS_W-1:0]          lhs_ff;
   logic [sac_pkg::RHS_W-1:0]          rhs_ff;
   logic                               hit_ff;
   logic                               rsp_valid_ff;
   logic                               pixel_valid_ff;
   logic                               match_ff;
   logic [sac_pkg::CNT_W-1:0]          match_cnt_ff;
   logic [sac_pkg::CNT_W-1:0]          valid_cnt_ff;

   logic [sac_pkg::C2_W-1:0]           cos_sq_in;
   logic [sac_pkg::DPROD_W-1:0]        digit_prod;
   logic [sac_pkg::ACC_W-1:0]          mul_sum;
   logic                               step_last;
   logic [sac_pkg::RHS_W-1:0]          lhs_scaled;
   logic                               zero_norm;
   logic                               hit_in;
   logic                               emit_load;

   assign pop       = (state_ff == ST_IDLE) && !fifo_status.empty;
   assign cos_sq_in = cos_threshold * cos_threshold;

   // The result register takes a new item once the previous one has been taken.
   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp.ready);

   // One multiplier digit per cycle, most significant digit first.
   assign digit_prod = mul_a_ff * mul_b_ff[DIGIT_HI:DIGIT_LO];
   assign mul_sum    = {mul_acc_ff[sac_pkg::ACC_W-sac_pkg::DIGIT_W-1:0],
                        {sac_pkg::DIGIT_W{1'b0}}}
                     + sac_pkg::ACC_W'(digit_prod);
   assign step_last  = step_ff == sac_pkg::STEP_W'(sac_pkg::MUL_STEPS - 1);

   // Angle test: an invalid pixel never matches, a zero norm is a right angle, a negative dot product never matches.
   assign lhs_scaled = {{LHS_PAD{1'b0}}, lhs_ff, {sac_pkg::LHS_SHIFT{1'b0}}};
   assign zero_norm  = (sums_ff.pixel_norm == '0) || (sums_ff.ref_norm == '0);
   always_comb begin
      if (sums_ff.invalid) begin
         hit_in = 1'b0;
      end else if (zero_norm) begin
         hit_in = cos_ff == '0;
      end else begin
         hit_in = !sums_ff.dot[sac_pkg::SUM_W-1] && (lhs_scaled >= rhs_ff);
      end
   end

   // Sequencer, multiplier registers, counters and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         match_cnt_ff <= '0;
         valid_cnt_ff <= '0;
      end else begin
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!fifo_status.empty) begin
                  sums_ff    <= head;
                  cos_ff     <= cos_threshold;
                  cos_sq_ff  <= cos_sq_in;
                  mul_a_ff   <= sac_pkg::MULA_W'(head.dot[sac_pkg::SUM_W-2:0]);
                  mul_b_ff   <= sac_pkg::MULB_W'(head.dot[sac_pkg::SUM_W-2:0]);
                  mul_acc_ff <= '0;
                  step_ff    <= '0;
                  state_ff   <= ST_DOT_SQ;
               end
            end
            ST_DOT_SQ, ST_NORM_PROD, ST_SCALE: begin
               if (step_last) begin
                  mul_acc_ff <= '0;
                  step_ff    <= '0;
                  case (state_ff)
                     ST_DOT_SQ: begin
                        lhs_ff   <= mul_sum[sac_pkg::LHS_W-1:0];
                        mul_a_ff <= sac_pkg::MULA_W'(sums_ff.pixel_norm);
                        mul_b_ff <= sac_pkg::MULB_W'(sums_ff.ref_norm);
                        state_ff <= ST_NORM_PROD;
                     end
                     ST_NORM_PROD: begin
                        mul_a_ff <= mul_sum[sac_pkg::MULA_W-1:0];
                        mul_b_ff <= sac_pkg::MULB_W'(cos_sq_ff);
                        state_ff <= ST_SCALE;
                     end
                     default: begin
                        rhs_ff   <= mul_sum[sac_pkg::RHS_W-1:0];
                        state_ff <= ST_DECIDE;
                     end
                  endcase
               end else begin
                  mul_acc_ff <= mul_sum;
                  mul_b_ff   <= mul_b_ff << sac_pkg::DIGIT_W;
                  step_ff    <= step_ff + 1'b1;
               end
            end
            ST_DECIDE: begin
               hit_ff   <= hit_in;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               // Load the result once the previous one has been taken.
               if (emit_load) begin
                  pixel_valid_ff <= !sums_ff.invalid;
                  match_ff       <= hit_ff;
                  if (!sums_ff.invalid && (valid_cnt_ff != '1)) begin
                     valid_cnt_ff <= valid_cnt_ff + 1'b1;
                  end
                  if (hit_ff && (match_cnt_ff != '1)) begin
                     match_cnt_ff <= match_cnt_ff + 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.pixel_valid   = pixel_valid_ff;
   assign rsp.match         = match_ff;
   assign rsp.matched_count = match_cnt_ff;
   assign rsp.total_count   = valid_cnt_ff;

endmodule

`default_nettype wire

### rtl/spectral_angle_classifier.sv
// Top level of the spectral angle classifier: threshold register, accumulator, queue and decision unit.
//
//   Channel   Direction  Moves
//   req_chan  in         one band item: pixel and reference sample, validity, last band
//   rsp_chan  out        one pixel item: pixel valid, match, matched and valid counts
//   csr_wr_*  in         cos_threshold write, Q1.16
//
// Band items are taken one per cycle; the decision unit works on one pixel at a time,
// with its 6-digit serial multiplier run three times (dot squared, norm product, scale).
// Up to 4 finished pixels wait in the queue; band items stall while it cannot take more.
// A pixel's sums pass from the product stage through the queue to the decision unit.
// Reset is synchronous, one cycle, and needs no clearing pass.
`default_nettype none
`include "spectral_angle_classifier_macros.svh"

module spectral_angle_classifier (
   input  wire                         clock,
   input  wire                         reset,
   sac_req_if.sink                     req_chan,
   sac_rsp_if.source                   rsp_chan,
   input  wire                         csr_wr_en,
   input  wire [sac_pkg::COS_W-1:0]    csr_wr_data
);

   logic [sac_pkg::COS_W-1:0]   cos_threshold_ff;
   sac_pkg::fifo_push_type      push;
   sac_pkg::fifo_status_type    fifo_status;
   sac_pkg::pixel_sums_type     head;
   logic                        pop;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_threshold_ff <= sac_pkg::COS_RESET;
      end else if (csr_wr_en) begin
         cos_threshold_ff <= csr_wr_data;
      end
   end

   sac_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .fifo_status (fifo_status),
      .push        (push)
   );

   sac_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (fifo_status),
      .head   (head)
   );

   sac_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cos_threshold (cos_threshold_ff),
      .fifo_status   (fifo_status),
      .head          (head),
      .pop           (pop),
      .rsp           (rsp_chan)
   );

   // The accumulator never pushes into a full queue, and the decision unit never pops an empty one.
   `SAC_ASSERT_IMPL(a_push_not_full, clock, reset, push.valid, !fifo_status.full)
   `SAC_ASSERT_IMPL(a_pop_not_empty, clock, reset, pop, !fifo_status.empty)
   // A pop without a push drops the fill count by one.
   `SAC_ASSERT_NEXT(a_pop_count, clock, reset, pop && !push.valid, fifo_status.count == $past(fifo_status.count) - 1'b1)
   // Matches are counted only for valid pixels, so they never exceed the valid count.
   `SAC_ASSERT_IMPL(a_count_order, clock, reset, rsp_chan.valid, rsp_chan.matched_count <= rsp_chan.total_count)

endmodule

`default_nettype wire

### sim/tb_top.sv
// Testbench for the spectral angle classifier: band stimulus, bit-exact prediction, result checks.
`timescale 1ns / 1ps

module tb_top;

   localparam int           WATCHDOG_LIMIT = 4000;
   localparam int           DRAIN_CYCLES   = 40;
   localparam int           HOLD_CYCLES    = 400;
   localparam longint       DOT_HI         = 64'sh3FF_FFFF_FFFF;
   localparam longint       DOT_LO         = -DOT_HI - 1;
   localparam longint unsigned NORM_HI     = 64'h7FF_FFFF_FFFF;

   // Kinds of random pixel spectra.
   typedef enum logic [1:0] {
      SPEC_RANDOM,
      SPEC_NEAR,
      SPEC_SMALL,
      SPEC_NOISY
   } spectrum_kind_type;

   typedef struct packed {
      logic signed [sac_pkg::SAMPLE_W-1:0] pixel_sample;
      logic signed [sac_pkg::SAMPLE_W-1:0] ref_sample;
      logic                                sample_valid;
      logic                                last_band;
   } band_type;

   typedef struct packed {
      logic                      pixel_valid;
      logic                      match;
      logic [sac_pkg::CNT_W-1:0] matched_count;
      logic [sac_pkg::CNT_W-1:0] total_count;
   } pixel_result_type;

   // Angle predictor and queue of pixel results still to come out of the block.
   class pixel_scoreboard_type;
      logic [sac_pkg::COS_W-1:0] cos_thr;
      longint                    dot_sum;
      longint unsigned           pix_norm;
      longint unsigned           ref_norm;
      bit                        invalid_seen;
      logic [sac_pkg::CNT_W-1:0] match_cnt;
      logic [sac_pkg::CNT_W-1:0] valid_cnt;
      pixel_result_type          expected_q[$];
      int                        errors;
      int                        results_seen;
      int                        null_seen;
      int                        match_seen;

      function new();
         cos_thr      = sac_pkg::COS_RESET;
         dot_sum      = 0;
         pix_norm     = 0;
         ref_norm     = 0;
         invalid_seen = 0;
         match_cnt    = '0;
         valid_cnt    = '0;
         errors       = 0;
         results_seen = 0;
         null_seen    = 0;
         match_seen   = 0;
      endfunction

      function void set_threshold(logic [sac_pkg::COS_W-1:0] value);
         cos_thr = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Accumulates one band item; the last band of a pixel queues its result.
      function void note_band(band_type b);
         longint           ps;
         longint           rs;
         longint           d;
         longint unsigned  n;
         logic [127:0]     lhs;
         logic [127:0]     rhs;
         logic             hit;
         pixel_result_type r;
         if (b.sample_valid) begin
            ps = longint'(b.pixel_sample);
            rs = longint'(b.ref_sample);
            d  = dot_sum + ps * rs;
            if (d > DOT_HI) d = DOT_HI;
            if (d < DOT_LO) d = DOT_LO;
            dot_sum  = d;
            n        = pix_norm + longint'(ps * ps);
            pix_norm = (n > NORM_HI) ? NORM_HI : n;
            n        = ref_norm + longint'(rs * rs);
            ref_norm = (n > NORM_HI) ? NORM_HI : n;
         end else begin
            invalid_seen = 1;
         end
         if (!b.last_band) return;

         // Decision without acos: compare dot^2 * 2^32 with c^2 * |p|^2 * |r|^2.
         hit = 1'b0;
         if (!invalid_seen) begin
            if (pix_norm == 0 || ref_norm == 0) begin
               hit = (cos_thr == 0);
            end else if (dot_sum >= 0) begin
               lhs = (128'(dot_sum) * 128'(dot_sum)) << 32;
               rhs = 128'(pix_norm) * 128'(ref_norm) * 128'(cos_thr) * 128'(cos_thr);
               hit = (lhs >= rhs);
            end
            if (valid_cnt != '1) valid_cnt++;
            if (hit && match_cnt != '1) match_cnt++;
         end
         r.pixel_valid   = !invalid_seen;
         r.match         = hit;
         r.matched_count = match_cnt;
         r.total_count   = valid_cnt;
         expected_q.push_back(r);

         dot_sum      = 0;
         pix_norm     = 0;
         ref_norm     = 0;
         invalid_seen = 0;
      endfunction

      // Compares one pixel result from the block with the oldest prediction.
      function void check_result(pixel_result_type got);
         pixel_result_type exp_r;
         if (expected_q.size() == 0) begin
            $display("%0t: pixel result with none expected: valid %0d match %0d counts %0d/%0d",
                     $time, got.pixel_valid, got.match, got.matched_count, got.total_count);
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         results_seen++;
         if (!exp_r.pixel_valid) null_seen++;
         if (exp_r.match) match_seen++;
         if (got.pixel_valid !== exp_r.pixel_valid) begin
            $display("%0t: pixel_valid mismatch: expected %0d actual %0d",
                     $time, exp_r.pixel_valid, got.pixel_valid);
            errors++;
         end
         if (got.match !== exp_r.match) begin
            $display("%0t: match mismatch: expected %0d actual %0d",
                     $time, exp_r.match, got.match);
            errors++;
         end
         if (got.matched_count !== exp_r.matched_count) begin
            $display("%0t: matched_count mismatch: expected %0d actual %0d",
                     $time, exp_r.matched_count, got.matched_count);
            errors++;
         end
         if (got.total_count !== exp_r.total_count) begin
            $display("%0t: total_count mismatch: expected %0d actual %0d",
                     $time, exp_r.total_count, got.total_count);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [sac_pkg::COS_W-1:0] csr_wr_data;

   sac_req_if req_chan();
   sac_rsp_if rsp_chan();

   spectral_angle_classifier dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pixel_scoreboard_type sb = new();

   bit idle_on       = 1'b1;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int bands_sent    = 0;
   int bands_taken   = 0;
   int settings_used = 1;
   int quiet_cycles  = 0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result receiver: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left      = HOLD_CYCLES - 1;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = !idle_on || ($urandom_range(99, 0) >= 23);
         end
      end
   end

   // Monitor: feeds accepted band items to the predictor, checks results, runs the watchdog.
   always @(posedge clock) begin
      band_type         b;
      pixel_result_type r;
      if (!reset) begin
         quiet_cycles++;
         if (req_chan.valid && req_chan.ready) begin
            b.pixel_sample = req_chan.pixel_sample;
            b.ref_sample   = req_chan.ref_sample;
            b.sample_valid = req_chan.sample_valid;
            b.last_band    = req_chan.last_band;
            sb.note_band(b);
            bands_taken++;
            quiet_cycles = 0;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            r.pixel_valid   = rsp_chan.pixel_valid;
            r.match         = rsp_chan.match;
            r.matched_count = rsp_chan.matched_count;
            r.total_count   = rsp_chan.total_count;
            sb.check_result(r);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d pixel results outstanding",
                     $time, quiet_cycles, sb.pending());
            $display("spectral_angle_classifier verification failed");
            $finish;
         end
      end
   end

   // Offers one band item, after an optional random gap, and waits until it is taken.
   task automatic push_band(input int ps, input int rs, input int ok, input int last);
      while (idle_on && $urandom_range(99, 0) < 23) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid        = 1'b1;
      req_chan.pixel_sample = sac_pkg::SAMPLE_W'(ps);
      req_chan.ref_sample   = sac_pkg::SAMPLE_W'(rs);
      req_chan.sample_valid = (ok != 0);
      req_chan.last_band    = (last != 0);
      bands_sent++;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Stops offering items until every pixel result is back and the block has settled.
   task automatic wait_idle();
      req_chan.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input int value);
      wait_idle();
      csr_wr_en   = 1'b1;
      csr_wr_data = sac_pkg::COS_W'(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.set_threshold(sac_pkg::COS_W'(value));
      settings_used++;
   endtask

   // Sends one pixel of the given kind; the last band carries the last-band flag.
   task automatic send_pixel(input int n_bands, input spectrum_kind_type kind);
      int                                  amp;
      int                                  num;
      int                                  v;
      logic signed [sac_pkg::SAMPLE_W-1:0] ps;
      logic signed [sac_pkg::SAMPLE_W-1:0] rs;
      logic                                ok;
      amp = $urandom_range(2048, 0);
      num = $urandom_range(16, 4);
      for (int i = 0; i < n_bands; i++) begin
         rs = sac_pkg::SAMPLE_W'($urandom);
         ps = sac_pkg::SAMPLE_W'($urandom);
         case (kind)
            SPEC_NEAR: begin
               // Scaled copy of the reference plus noise, so angles fall near the threshold.
               v = (int'(rs) * num) / 16 + int'($urandom_range(2 * amp, 0)) - amp;
               if (v > 32767) v = 32767;
               if (v < -32768) v = -32768;
               ps = sac_pkg::SAMPLE_W'(v);
            end
            SPEC_SMALL: begin
               ps = sac_pkg::SAMPLE_W'(int'($urandom_range(8, 0)) - 4);
               rs = sac_pkg::SAMPLE_W'(int'($urandom_range(8, 0)) - 4);
            end
            default: begin
            end
         endcase
         ok = (kind == SPEC_NOISY) ? ($urandom_range(99, 0) >= 30)
                                   : ($urandom_range(99, 0) >= 3);
         push_band(int'(ps), int'(rs), int'(ok), int'(i == n_bands - 1));
      end
   endtask

   // Random pixels, mostly short, until about n_items band items have gone out.
   task automatic run_random(input int n_items);
      int start;
      int pick;
      int n_bands;
      start = bands_sent;
      while (bands_sent - start < n_items) begin
         pick = $urandom_range(99, 0);
         if (pick < 80) n_bands = $urandom_range(6, 1);
         else if (pick < 95) n_bands = $urandom_range(24, 7);
         else n_bands = $urandom_range(64, 25);
         pick = $urandom_range(99, 0);
         if (pick < 30) send_pixel(n_bands, SPEC_RANDOM);
         else if (pick < 70) send_pixel(n_bands, SPEC_NEAR);
         else if (pick < 85) send_pixel(n_bands, SPEC_SMALL);
         else send_pixel(n_bands, SPEC_NOISY);
      end
   endtask

   // Stimulus sequence.
   initial begin
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_chan.valid        = 1'b0;
      req_chan.pixel_sample = '0;
      req_chan.ref_sample   = '0;
      req_chan.sample_valid = 1'b0;
      req_chan.last_band    = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed pixels at the threshold left by reset.
      push_band(32767, 32767, 1, 1);
      push_band(-32768, -32768, 1, 1);
      push_band(-32768, 32767, 1, 1);
      push_band(0, 12345, 1, 1);
      push_band(12345, 0, 1, 1);
      push_band(16384, 0, 1, 0);
      push_band(0, 16384, 1, 1);
      push_band(1000, 1000, 1, 0);
      push_band(2000, 1990, 1, 0);
      push_band(-500, -510, 1, 1);
      push_band(32767, 32767, 0, 0);
      push_band(100, 100, 1, 1);
      push_band(100, 100, 1, 0);
      push_band(-32768, -32768, 0, 1);
      push_band(0, 0, 0, 1);
      push_band(1, 1, 1, 1);
      run_random(250);

      // Zero threshold: right angles and zero norms match; the receiver holds off once.
      write_threshold(0);
      push_band(0, 0, 1, 1);
      push_band(16384, 0, 1, 0);
      push_band(0, 16384, 1, 1);
      push_band(5, -5, 1, 1);
      hold_requests++;
      run_random(250);

      // Threshold of exactly one: only parallel spectra match.
      write_threshold(65536);
      push_band(32767, 32767, 1, 1);
      run_random(250);

      // Thresholds above one never match.
      write_threshold(65537);
      push_band(32767, 32767, 1, 1);
      run_random(100);
      write_threshold(131071);
      run_random(150);

      // A long stretch with no idling on either side.
      write_threshold(65535);
      idle_on = 1'b0;
      run_random(250);
      idle_on = 1'b1;

      write_threshold(1);
      run_random(150);

      // Mid-range thresholds, with one pause of the sender until all results are back.
      write_threshold($urandom_range(65535, 40000));
      run_random(150);
      wait_idle();
      run_random(150);
      write_threshold($urandom_range(65535, 55000));
      run_random(150);

      wait_idle();
      $display("Run covered %0d band items and %0d pixel results (%0d null, %0d matching)",
               bands_taken, sb.results_seen, sb.null_seen, sb.match_seen);
      $display("over %0d threshold settings, with receiver hold-off, sender pause and no-idle run.",
               settings_used);
      if (sb.errors == 0) begin
         $display("spectral_angle_classifier verification clean");
      end else begin
         $display("spectral_angle_classifier verification failed");
      end
      $finish;
   end

endmodule
